FILE: src/kecd_pkg.sv
package kecd_pkg;

	// Special key codes produced by the key ROM and by the Fn arrow layer.
	localparam logic [7:0] KEY_BKSP        = 8'h2A;
	localparam logic [7:0] KEY_TAB         = 8'h2B;
	localparam logic [7:0] KEY_RETURN      = 8'h28;
	localparam logic [7:0] KEY_FN          = 8'hFF;
	localparam logic [7:0] KEY_ARROW_RIGHT = 8'hD7;
	localparam logic [7:0] KEY_ARROW_LEFT  = 8'hD8;
	localparam logic [7:0] KEY_ARROW_DOWN  = 8'hD9;
	localparam logic [7:0] KEY_ARROW_UP    = 8'hDA;

	// Printable keys that the decoder looks at.
	localparam logic [7:0] KEY_BACKTICK = 8'h60;
	localparam logic [7:0] KEY_SPACE    = 8'h20;
	localparam logic [7:0] KEY_N        = 8'h6E;
	localparam logic [7:0] KEY_P        = 8'h70;
	localparam logic [7:0] KEY_R        = 8'h72;
	localparam logic [7:0] KEY_B        = 8'h62;
	localparam logic [7:0] KEY_DOT      = 8'h2E;
	localparam logic [7:0] KEY_SLASH    = 8'h2F;
	localparam logic [7:0] KEY_SEMI     = 8'h3B;
	localparam logic [7:0] KEY_COMMA    = 8'h2C;
	localparam logic [7:0] KEY_ONE      = 8'h31;
	localparam logic [7:0] KEY_FOUR     = 8'h34;

	// Event byte layout.
	localparam int unsigned PRESS_BIT = 7;

	// Counter limits.
	localparam logic [15:0] HOLD_MAX = 16'hFFFF;
	localparam logic [9:0]  GAP_MAX  = 10'h3FF;

	// Register reset values.
	localparam logic [15:0] HOLD_MS_RST    = 16'd5000;
	localparam logic [9:0]  NAV_GAP_MS_RST = 10'd180;

	// Register indexes on the configuration port.
	localparam logic REG_HOLD_MS    = 1'b0;
	localparam logic REG_NAV_GAP_MS = 1'b1;

	// Item kinds carried on tuser.
	localparam logic KIND_EVENT = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef enum logic [2:0] {
		CMD_NEXT   = 3'd0,
		CMD_PREV   = 3'd1,
		CMD_ROTATE = 3'd2,
		CMD_LIGHT  = 3'd3,
		CMD_SELECT = 3'd4,
		CMD_RESET  = 3'd5
	} cmd_t;

	// Decoded keypad event.
	typedef struct packed {
		logic       valid;
		logic       press;
		logic [7:0] key;
	} key_info_t;

	// One possible result of a decoded item.
	typedef struct packed {
		logic       hit;
		cmd_t       cmd;
		logic [1:0] screen;
	} kecd_res_t;

	// Decoder status seen by the top level.
	typedef struct packed {
		logic fn_down;
		logic erase_held;
	} kecd_stat_t;

	// Physical 4x14 layout, row-major.
	localparam int unsigned ROM_DEPTH = 56;
	localparam logic [7:0] KEY_ROM [0:ROM_DEPTH-1] = '{
		8'h60, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h2A,
		8'h2B, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79,
		8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h5C,
		8'hFF, 8'h81, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67,
		8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h28,
		8'h80, 8'h00, 8'h82, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h20
	};

	// ROM read; indexes past the end only occur for rejected keycodes.
	function automatic logic [7:0] key_rom_read(input logic [5:0] idx);
		logic [7:0] val;
		val = 8'h00;
		if (idx < 6'(ROM_DEPTH)) begin
			val = KEY_ROM[idx];
		end
		return val;
	endfunction

endpackage

FILE: src/kecd_keymap.sv
module kecd_keymap (
	input  logic [7:0]          raw_event,
	output kecd_pkg::key_info_t info
);
	import kecd_pkg::*;

	logic [6:0]  code;
	logic [6:0]  code_m1;
	logic [14:0] prod;
	logic [3:0]  srow;
	logic [6:0]  rem;
	logic [3:0]  scol;
	logic [5:0]  idx;

	// Split keycode-1 into scan row and column: x/10 as (x*205)>>11, exact for x < 1029.
	always_comb begin
		code    = raw_event[6:0];
		code_m1 = code - 7'd1;
		prod    = 15'(code_m1) * 15'd205;
		srow    = prod[14:11];
		rem     = code_m1 - 7'(7'(srow) * 7'd10);
		scol    = rem[3:0];
	end

	// Remap 7x8 scan position to the 4x14 layout and look up the key.
	always_comb begin
		idx        = 6'(6'(scol[1:0]) * 6'd14) + 6'({srow[2:0], scol[2]});
		info.valid = (code != 7'd0) && (srow <= 4'd6) && (scol <= 4'd7);
		info.press = raw_event[PRESS_BIT];
		info.key   = key_rom_read(idx);
	end

endmodule

FILE: src/kecd_core.sv
module kecd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 kind,
	input  kecd_pkg::key_info_t  info,
	input  logic [15:0]          hold_ms,
	input  logic [9:0]           nav_gap_ms,
	output kecd_pkg::kecd_res_t  res,
	output kecd_pkg::kecd_stat_t stat
);
	import kecd_pkg::*;

	logic        fn_down_q, fn_down_d;
	logic        erase_held_q, erase_held_d;
	logic [15:0] hold_ticks_q, hold_ticks_d;
	logic [9:0]  since_q, since_d;
	logic [15:0] hold_inc;
	logic [7:0]  nav_key;

	// Decoder state, updated once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fn_down_q    <= 1'b0;
			erase_held_q <= 1'b0;
			hold_ticks_q <= '0;
			since_q      <= '0;
		end else if (en) begin
			fn_down_q    <= fn_down_d;
			erase_held_q <= erase_held_d;
			hold_ticks_q <= hold_ticks_d;
			since_q      <= since_d;
		end
	end

	assign hold_inc = (hold_ticks_q != HOLD_MAX) ? hold_ticks_q + 16'd1 : hold_ticks_q;

	// Fn arrow layer.
	always_comb begin
		nav_key = info.key;
		if (fn_down_q) begin
			priority if (info.key == KEY_DOT) begin
				nav_key = KEY_ARROW_DOWN;
			end else if (info.key == KEY_SEMI) begin
				nav_key = KEY_ARROW_UP;
			end else if (info.key == KEY_COMMA) begin
				nav_key = KEY_ARROW_LEFT;
			end else if (info.key == KEY_SLASH) begin
				nav_key = KEY_ARROW_RIGHT;
			end else begin
				// Keys outside the punctuation cluster pass through.
			end
		end
	end

	// Next state and result for the item in the input register.
	always_comb begin
		fn_down_d    = fn_down_q;
		erase_held_d = erase_held_q;
		hold_ticks_d = hold_ticks_q;
		since_d      = since_q;
		res.hit      = 1'b0;
		res.cmd      = CMD_NEXT;
		res.screen   = 2'd0;
		if (kind == KIND_TICK) begin
			if (since_q != GAP_MAX) begin
				since_d = since_q + 10'd1;
			end
			if (erase_held_q) begin
				hold_ticks_d = hold_inc;
				if (hold_inc >= hold_ms) begin
					erase_held_d = 1'b0;
					res.hit      = 1'b1;
					res.cmd      = CMD_RESET;
				end
			end
		end else if (info.valid) begin
			priority if (info.key == KEY_FN) begin
				fn_down_d = info.press;
			end else if (info.key == KEY_BKSP) begin
				if (info.press) begin
					if (!erase_held_q) begin
						erase_held_d = 1'b1;
						hold_ticks_d = '0;
					end
				end else if (erase_held_q) begin
					erase_held_d = 1'b0;
					res.hit      = 1'b1;
					res.cmd      = CMD_PREV;
				end
			end else if (!info.press) begin
				// Other releases do nothing.
			end else if (fn_down_q && info.key == KEY_BACKTICK) begin
				res.hit = 1'b1;
				res.cmd = CMD_LIGHT;
			end else if (since_q >= nav_gap_ms) begin
				// Any press past the gap restarts it, whether or not it maps.
				since_d = '0;
				priority if (nav_key == KEY_ARROW_DOWN || nav_key == KEY_ARROW_RIGHT ||
						nav_key == KEY_RETURN || nav_key == KEY_SPACE ||
						nav_key == KEY_N || nav_key == KEY_DOT ||
						nav_key == KEY_SLASH || nav_key == KEY_SEMI) begin
					res.hit = 1'b1;
					res.cmd = CMD_NEXT;
				end else if (nav_key == KEY_ARROW_UP || nav_key == KEY_ARROW_LEFT ||
						nav_key == KEY_P || nav_key == KEY_COMMA) begin
					res.hit = 1'b1;
					res.cmd = CMD_PREV;
				end else if (nav_key == KEY_R) begin
					res.hit = 1'b1;
					res.cmd = CMD_ROTATE;
				end else if (nav_key == KEY_B || nav_key == KEY_TAB) begin
					res.hit = 1'b1;
					res.cmd = CMD_LIGHT;
				end else if (nav_key >= KEY_ONE && nav_key <= KEY_FOUR) begin
					res.hit    = 1'b1;
					res.cmd    = CMD_SELECT;
					res.screen = 2'(nav_key - KEY_ONE);
				end else begin
					// Keys without a command only restart the gap.
				end
			end else begin
				// Presses inside the gap are ignored.
			end
		end
	end

	assign stat.fn_down    = fn_down_q;
	assign stat.erase_held = erase_held_q;

endmodule

FILE: src/keypad_event_command_decoder_unit.sv
// Keypad event command decoder.
// An accepted item is held in the input register and decoded; any command it yields
// is loaded into the result register, which drives master-side tvalid.
// Throughput: one item per cycle; the decode between the input register and the
// result register is a single pass, and the input stalls only while a result waits.
// Reset: arst_n clears all decoder state and valid flags, and loads the
// registers with their defaults (hold_ms 5000, nav_gap_ms 180).
module keypad_event_command_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream: tdata = raw_event[7:0]; tuser = kind[0].
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	// Result stream: tdata = command[2:0], screen_index[4:3], zero[7:5].
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import kecd_pkg::*;

	logic                valid_s1;
	logic                kind_s1;
	logic [7:0]          raw_s1;
	logic                adv;
	logic                cfg_wr;
	logic [15:0]         hold_ms_q;
	logic [9:0]          nav_gap_ms_q;
	logic                out_valid_q;
	cmd_t                out_cmd_q;
	logic [1:0]          out_screen_q;
	key_info_t           info;
	kecd_res_t           res;
	kecd_stat_t          stat;

	// Configuration registers; the register index is the word address.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ms_q    <= HOLD_MS_RST;
			nav_gap_ms_q <= NAV_GAP_MS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_HOLD_MS) begin
				hold_ms_q <= pwdata[15:0];
			end else begin
				nav_gap_ms_q <= pwdata[9:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_NAV_GAP_MS) ? {22'd0, nav_gap_ms_q} : {16'd0, hold_ms_q};

	// The input register item is processed when the result register is free or its result is being taken.
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser[0];
			raw_s1  <= s_axis_tdata;
		end
	end

	kecd_keymap u_keymap (
		.raw_event (raw_s1),
		.info      (info)
	);

	kecd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.kind       (kind_s1),
		.info       (info),
		.hold_ms    (hold_ms_q),
		.nav_gap_ms (nav_gap_ms_q),
		.res        (res),
		.stat       (stat)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res.hit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_cmd_q    <= res.cmd;
			out_screen_q <= res.screen;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_screen_q, out_cmd_q};

	// A free result register never blocks the input side.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_axis_tready)
		else $error("input stalled while the result register was free");

	// Only the select command carries a screen number.
	a_screen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_cmd_q != CMD_SELECT) |-> (out_screen_q == 2'd0))
		else $error("screen number set on a non-select command");

	// The backspace hold ends only with a reset or previous command.
	a_hold_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stat.erase_held) |-> $past(adv && res.hit &&
			(res.cmd == CMD_RESET || res.cmd == CMD_PREV)))
		else $error("backspace hold cleared without a command");

	// A decoded reset command lands in the result register.
	a_reset_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.hit && res.cmd == CMD_RESET) |=> (out_valid_q && out_cmd_q == CMD_RESET))
		else $error("reset command lost in the result register");

endmodule

FILE: dv/tb_keypad_event_command_decoder_unit.sv
module tb_keypad_event_command_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import kecd_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 6;

	// Physical 4x14 layout, row-major, element 0 leftmost.
	localparam logic [0:55][7:0] KEY_LAYOUT = {
		112'h6031323334353637383930_2D3D2A,
		112'h2B71776572747975696F705B5D5C,
		112'hFF8161736466676_86A6B6C3B2728,
		112'h8000827A7863766_26E6D2C2E2F20
	};

	// Keys that steer the decoder, with backspace listed twice so holds happen often.
	localparam logic [0:19][7:0] HOT_KEYS = {
		KEY_N, KEY_P, KEY_R, KEY_B, KEY_TAB, KEY_RETURN, KEY_SPACE, KEY_ONE,
		KEY_ONE + 8'd1, KEY_ONE + 8'd2, KEY_FOUR, KEY_DOT, KEY_SEMI, KEY_COMMA,
		KEY_SLASH, KEY_BACKTICK, KEY_BKSP, KEY_BKSP, KEY_FN, 8'h61
	};

	typedef struct {
		cmd_t       command;
		logic [1:0] screen;
	} cmd_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic [0:0]  s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b1;
	logic [7:0]  m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// Decoder state and registers as the testbench sees them.
	logic [15:0] cfg_hold_ms = 16'd5000;
	logic [9:0]  cfg_nav_gap = 10'd180;
	logic        fn_held = 1'b0;
	logic        bksp_down = 1'b0;
	logic [15:0] bksp_ticks = 16'd0;
	logic [9:0]  nav_ticks = 10'd0;

	cmd_rec_t awaited_cmds[$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	bit       sender_idle_on = 1'b1;
	bit       sink_stall_on = 1'b1;

	keypad_event_command_decoder_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Runaway guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40) begin
			$display("MISMATCH cycle %0d: %s", cycle_count, what);
		end
	endtask

	// Scan keycode to physical key; returns 0 for keycodes the decoder rejects.
	function automatic bit scan_lookup(input logic [6:0] code, output logic [7:0] key);
		int unsigned srow;
		int unsigned scol;
		key = 8'h00;
		if (code == 7'd0) begin
			return 1'b0;
		end
		srow = (int'(code) - 1) / 10;
		scol = (int'(code) - 1) % 10;
		if (srow > 6 || scol > 7) begin
			return 1'b0;
		end
		key = KEY_LAYOUT[(scol % 4) * 14 + srow * 2 + (scol > 3 ? 1 : 0)];
		return 1'b1;
	endfunction

	function automatic logic [6:0] code_of(input logic [7:0] key);
		logic [7:0] found;
		for (int c = 1; c < 128; c++) begin
			if (scan_lookup(7'(c), found) && found == key) begin
				return 7'(c);
			end
		end
		return 7'd0;
	endfunction

	function automatic void await_cmd(input cmd_t command, input logic [1:0] screen);
		cmd_rec_t rec;
		rec.command = command;
		rec.screen  = screen;
		awaited_cmds.push_back(rec);
	endfunction

	// Updates the decoder state for one accepted item and queues its command, if any.
	task automatic decode_item(input logic kind, input logic [7:0] raw);
		logic [7:0] key;
		logic       down;
		if (kind == KIND_TICK) begin
			if (nav_ticks < GAP_MAX) begin
				nav_ticks++;
			end
			if (bksp_down) begin
				if (bksp_ticks < HOLD_MAX) begin
					bksp_ticks++;
				end
				if (bksp_ticks >= cfg_hold_ms) begin
					bksp_down = 1'b0;
					await_cmd(CMD_RESET, 2'd0);
				end
			end
		end else if (scan_lookup(raw[6:0], key)) begin
			down = raw[PRESS_BIT];
			if (key == KEY_FN) begin
				fn_held = down;
			end else if (key == KEY_BKSP) begin
				if (down) begin
					if (!bksp_down) begin
						bksp_down  = 1'b1;
						bksp_ticks = 16'd0;
					end
				end else if (bksp_down) begin
					bksp_down = 1'b0;
					await_cmd(CMD_PREV, 2'd0);
				end
			end else if (down) begin
				if (fn_held && key == KEY_BACKTICK) begin
					await_cmd(CMD_LIGHT, 2'd0);
				end else begin
					// Fn turns the punctuation cluster into arrows.
					if (fn_held) begin
						case (key)
							KEY_DOT:   key = KEY_ARROW_DOWN;
							KEY_SEMI:  key = KEY_ARROW_UP;
							KEY_COMMA: key = KEY_ARROW_LEFT;
							KEY_SLASH: key = KEY_ARROW_RIGHT;
							default:   key = key;
						endcase
					end
					// Any press past the gap restarts it, command or not.
					if (nav_ticks >= cfg_nav_gap) begin
						nav_ticks = 10'd0;
						case (key)
							KEY_ARROW_DOWN, KEY_ARROW_RIGHT, KEY_RETURN, KEY_SPACE,
							KEY_N, KEY_DOT, KEY_SLASH, KEY_SEMI: begin
								await_cmd(CMD_NEXT, 2'd0);
							end
							KEY_ARROW_UP, KEY_ARROW_LEFT, KEY_P, KEY_COMMA: begin
								await_cmd(CMD_PREV, 2'd0);
							end
							KEY_R: begin
								await_cmd(CMD_ROTATE, 2'd0);
							end
							KEY_B, KEY_TAB: begin
								await_cmd(CMD_LIGHT, 2'd0);
							end
							default: begin
								if (key >= KEY_ONE && key <= KEY_FOUR) begin
									await_cmd(CMD_SELECT, 2'(key - KEY_ONE));
								end
							end
						endcase
					end
				end
			end
		end
	endtask

	// Sends one item and predicts it at the edge where the transaction completes.
	task automatic send_item(input logic kind, input logic [7:0] raw);
		int gap;
		if (sender_idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= raw;
		s_axis_tuser  <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		decode_item(kind, raw);
	endtask

	task automatic press_key(input logic [7:0] key, input logic down);
		send_item(KIND_EVENT, {down, code_of(key)});
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_item(KIND_TICK, 8'($urandom));
	endtask

	task automatic wait_all_results();
		s_axis_tvalid <= 1'b0;
		while (awaited_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic read_reg(input logic idx, input logic [31:0] want);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			report_mismatch($sformatf("register %0d reads %0d, want %0d", idx, prdata, want));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Register writes happen only once the block has gone quiet; each is read back.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		wait_all_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_HOLD_MS) begin
			cfg_hold_ms = value[15:0];
			read_reg(idx, {16'd0, cfg_hold_ms});
		end else begin
			cfg_nav_gap = value[9:0];
			read_reg(idx, {22'd0, cfg_nav_gap});
		end
	endtask

	// Result checker: every completed output transaction against the oldest prediction.
	always @(posedge clk) begin : check_results
		cmd_rec_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (awaited_cmds.size() == 0) begin
				report_mismatch($sformatf("unexpected result tdata=%h", m_axis_tdata));
			end else begin
				want = awaited_cmds.pop_front();
				if (m_axis_tdata[2:0] !== want.command) begin
					report_mismatch($sformatf("command %0d, want %0d",
						m_axis_tdata[2:0], want.command));
				end
				if (m_axis_tdata[4:3] !== want.screen) begin
					report_mismatch($sformatf("screen_index %0d, want %0d",
						m_axis_tdata[4:3], want.screen));
				end
			end
		end
	end

	// Receiver back-pressure in random bursts.
	initial begin
		forever begin
			@(posedge clk);
			if (sink_stall_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic test_reset_values();
		read_reg(REG_HOLD_MS, {16'd0, cfg_hold_ms});
		read_reg(REG_NAV_GAP_MS, {22'd0, cfg_nav_gap});
	endtask

	// Keycode zero, scan rows past six and scan columns past seven change nothing.
	task automatic test_bad_keycodes();
		send_item(KIND_EVENT, 8'h00);
		send_item(KIND_EVENT, 8'h80);
		send_item(KIND_EVENT, 8'h89);
		send_item(KIND_EVENT, 8'h0A);
		send_item(KIND_EVENT, 8'hC7);
		send_item(KIND_EVENT, 8'hFF);
		send_item(KIND_EVENT, 8'h7F);
	endtask

	task automatic test_fn_layer();
		write_reg(REG_NAV_GAP_MS, 32'd0);
		press_key(KEY_FN, 1'b1);
		press_key(KEY_BACKTICK, 1'b1);
		press_key(KEY_DOT, 1'b1);
		press_key(KEY_SEMI, 1'b1);
		press_key(KEY_COMMA, 1'b1);
		press_key(KEY_SLASH, 1'b1);
		press_key(KEY_FN, 1'b0);
		press_key(KEY_SEMI, 1'b1);
		press_key(KEY_BACKTICK, 1'b1);
	endtask

	task automatic test_commands();
		for (int i = 0; i < 16; i++) begin
			press_key(HOT_KEYS[i], 1'b1);
		end
		press_key(8'h61, 1'b1);
		press_key(KEY_N, 1'b0);
	endtask

	task automatic test_backspace();
		write_reg(REG_HOLD_MS, 32'd3);
		press_key(KEY_BKSP, 1'b1);
		press_key(KEY_BKSP, 1'b0);
		press_key(KEY_BKSP, 1'b0);
		press_key(KEY_BKSP, 1'b1);
		press_key(KEY_BKSP, 1'b1);
		send_ticks(3);
		press_key(KEY_BKSP, 1'b0);
		write_reg(REG_HOLD_MS, 32'd1);
		press_key(KEY_BKSP, 1'b1);
		send_ticks(1);
	endtask

	task automatic test_rate_limit();
		write_reg(REG_NAV_GAP_MS, 32'd5);
		send_ticks(5);
		press_key(KEY_N, 1'b1);
		send_ticks(3);
		press_key(KEY_N, 1'b1);
		send_ticks(2);
		press_key(KEY_N, 1'b1);
		send_ticks(5);
		press_key(8'h61, 1'b1);
		press_key(KEY_N, 1'b1);
		press_key(KEY_FN, 1'b1);
		press_key(KEY_BACKTICK, 1'b1);
		press_key(KEY_FN, 1'b0);
	endtask

	task automatic test_random();
		int unsigned hold_set[6] = '{1, 16, 300, 4, 60, 2};
		int unsigned gap_set[6]  = '{0, 8, 1023, 2, 30, 0};
		int          sel;
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_HOLD_MS, hold_set[ph]);
			write_reg(REG_NAV_GAP_MS, gap_set[ph]);
			// The final phase runs without idling on either side.
			if (ph == 5) begin
				sender_idle_on = 1'b0;
				sink_stall_on  = 1'b0;
			end
			repeat (72) begin
				sel = $urandom_range(0, 99);
				if (sel < 35) begin
					send_item(KIND_TICK, 8'($urandom));
				end else if (sel < 88) begin
					press_key(HOT_KEYS[$urandom_range(0, 19)], $urandom_range(0, 9) < 7);
				end else begin
					send_item(KIND_EVENT, 8'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_bad_keycodes();
		test_fn_layer();
		test_commands();
		test_backspace();
		test_rate_limit();
		test_random();
		wait_all_results();
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: keypad_event_command_decoder_unit.f
src/kecd_pkg.sv
src/kecd_keymap.sv
src/kecd_core.sv
src/keypad_event_command_decoder_unit.sv
dv/tb_keypad_event_command_decoder_unit.sv
